/* src/swpc_pkg.sv */
// Package for the stack with palindrome check.
// Holds sizes, operation and status codes, the controller state type and the
// RAM request struct. No dependencies.
`timescale 1ns / 1ps

package swpc_pkg;

  localparam int DEPTH  = 16;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int OCC_W  = 5;

  localparam logic [1:0] FN_PUSH  = 2'd0;
  localparam logic [1:0] FN_POP   = 2'd1;
  localparam logic [1:0] FN_CHECK = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP_WAIT,
    S_CHK_RD,
    S_CHK_CMP
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
  } ram_req_t;

endpackage

/* src/swpc_ram.sv */
// Entry storage: one write port, two read ports, registered read data.
// Depends on swpc_pkg.
`timescale 1ns / 1ps

module swpc_ram (
  input  logic                      clk,
  input  swpc_pkg::ram_req_t        req,
  output logic [swpc_pkg::WORD_W-1:0] rd_a,
  output logic [swpc_pkg::WORD_W-1:0] rd_b
);

  logic [swpc_pkg::WORD_W-1:0] mem [0:swpc_pkg::DEPTH-1];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_a <= mem[req.raddr_a];
      rd_b <= mem[req.raddr_b];
    end
  end

endmodule

/* src/swpc_ctrl.sv */
// Stack controller: fill count, operation sequencing, palindrome walk and
// output register. Drives swpc_ram requests. Depends on swpc_pkg.
`timescale 1ns / 1ps

module swpc_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [1:0]                    func,
  input  logic [swpc_pkg::WORD_W-1:0]   push_value,
  input  logic                          m_tready,
  output logic                          m_tvalid,
  output logic [1:0]                    status,
  output logic [swpc_pkg::WORD_W-1:0]   popped_value,
  output logic                          is_palindrome,
  output logic [swpc_pkg::OCC_W-1:0]    occupancy,
  output swpc_pkg::ram_req_t            req,
  input  logic [swpc_pkg::WORD_W-1:0]   rd_a,
  input  logic [swpc_pkg::WORD_W-1:0]   rd_b
);

  swpc_pkg::state_t state, state_next;
  logic [swpc_pkg::CNT_W-1:0]  fill, fill_next;
  logic [swpc_pkg::ADDR_W-1:0] lo, hi;

  logic                        accept;
  logic                        full, empty, few;
  logic                        load;
  logic [1:0]                  status_next;
  logic [swpc_pkg::WORD_W-1:0] popped_next;
  logic                        pal_next;

  assign accept = s_tvalid && s_tready;
  assign full   = (fill == swpc_pkg::CNT_W'(swpc_pkg::DEPTH));
  assign empty  = (fill == '0);
  assign few    = ({1'b0, fill} < (swpc_pkg::CNT_W + 1)'(2));

  always_comb begin
    state_next = state;
    case (state)
      swpc_pkg::S_IDLE: begin
        if (accept) begin
          if (func == swpc_pkg::FN_POP && !empty) begin
            state_next = swpc_pkg::S_POP_WAIT;
          end else if (func == swpc_pkg::FN_CHECK && !few) begin
            state_next = swpc_pkg::S_CHK_RD;
          end
        end
      end
      swpc_pkg::S_POP_WAIT: state_next = swpc_pkg::S_IDLE;
      swpc_pkg::S_CHK_RD: begin
        state_next = (lo < hi) ? swpc_pkg::S_CHK_CMP : swpc_pkg::S_IDLE;
      end
      swpc_pkg::S_CHK_CMP: begin
        state_next = (rd_a == rd_b) ? swpc_pkg::S_CHK_RD : swpc_pkg::S_IDLE;
      end
      default: state_next = swpc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_tready    = (state == swpc_pkg::S_IDLE) && (!m_tvalid || m_tready);
    req         = '0;
    req.waddr   = fill[swpc_pkg::ADDR_W-1:0];
    req.wdata   = push_value;
    load        = 1'b0;
    status_next = swpc_pkg::ST_OK;
    popped_next = '0;
    pal_next    = 1'b0;
    fill_next   = fill;
    case (state)
      swpc_pkg::S_IDLE: begin
        if (accept) begin
          case (func)
            swpc_pkg::FN_PUSH: begin
              load = 1'b1;
              if (full) begin
                status_next = swpc_pkg::ST_OVERFLOW;
              end else begin
                req.we    = 1'b1;
                fill_next = fill + 1'b1;
              end
            end
            swpc_pkg::FN_POP: begin
              if (empty) begin
                load        = 1'b1;
                status_next = swpc_pkg::ST_UNDERFLOW;
              end else begin
                req.re      = 1'b1;
                req.raddr_a = swpc_pkg::ADDR_W'(fill - 1'b1);
                fill_next   = fill - 1'b1;
              end
            end
            swpc_pkg::FN_CHECK: begin
              if (few) begin
                load     = 1'b1;
                pal_next = 1'b1;
              end
            end
            default: load = 1'b1;
          endcase
        end
      end
      swpc_pkg::S_POP_WAIT: begin
        load        = 1'b1;
        popped_next = rd_a;
      end
      swpc_pkg::S_CHK_RD: begin
        if (lo < hi) begin
          req.re      = 1'b1;
          req.raddr_a = lo;
          req.raddr_b = hi;
        end else begin
          load     = 1'b1;
          pal_next = 1'b1;
        end
      end
      swpc_pkg::S_CHK_CMP: begin
        if (rd_a != rd_b) begin
          load = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= swpc_pkg::S_IDLE;
      fill     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status        <= status_next;
      popped_value  <= popped_next;
      is_palindrome <= pal_next;
      occupancy     <= swpc_pkg::OCC_W'(fill_next);
    end
    if (state == swpc_pkg::S_IDLE) begin
      lo <= '0;
      hi <= swpc_pkg::ADDR_W'(fill - 1'b1);
    end else if (state == swpc_pkg::S_CHK_CMP) begin
      lo <= lo + 1'b1;
      hi <= hi - 1'b1;
    end
  end

endmodule

/* src/stack_with_palindrome_check_unit.sv */
// Top level of the stack with palindrome check.
// Instantiates swpc_ctrl and swpc_ram; depends on swpc_pkg.
//
// Usage:
//   Slave channel s_*: one transaction per operation. s_tuser carries the
//   operation (push, pop, palindrome check), s_tdata the word to push.
//   Master channel m_*: one transaction per operation. m_tuser carries the
//   status (ok, overflow, underflow), m_tdata the popped word, the
//   palindrome flag and the occupancy after the operation.
//   Push, overflow, underflow and checks on fewer than two entries give a
//   result in the cycle after acceptance. Pop reads the RAM, then loads
//   the registered read data in S_POP_WAIT. A check alternates S_CHK_RD,
//   which reads one entry pair through the dual read port, and S_CHK_CMP,
//   which compares it, until the pointers meet or the first mismatch.
//   One operation is in flight at a time; a new one is taken once the
//   previous result is loaded into the output register and that register
//   is empty or being drained.
//   Reset empties the stack and drops any pending result; entry contents
//   need no clearing. When m_tready is low the result holds and s_tready
//   drops until it is taken.
`timescale 1ns / 1ps

module stack_with_palindrome_check_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tuser,  // [1:0] func
  input  logic [31:0] s_tdata,  // [31:0] push_value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tuser,  // [1:0] status
  output logic [39:0] m_tdata   // [31:0] popped_value, [32] is_palindrome, [37:33] occupancy
);

  swpc_pkg::ram_req_t              req;
  logic [swpc_pkg::WORD_W-1:0]     rd_a, rd_b;
  logic [1:0]                      status;
  logic [swpc_pkg::WORD_W-1:0]     popped_value;
  logic                            is_palindrome;
  logic [swpc_pkg::OCC_W-1:0]      occupancy;

  swpc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .func         (s_tuser[1:0]),
    .push_value   (s_tdata),
    .m_tready     (m_tready),
    .m_tvalid     (m_tvalid),
    .status       (status),
    .popped_value (popped_value),
    .is_palindrome(is_palindrome),
    .occupancy    (occupancy),
    .req          (req),
    .rd_a         (rd_a),
    .rd_b         (rd_b)
  );

  swpc_ram u_ram (
    .clk (clk),
    .req (req),
    .rd_a(rd_a),
    .rd_b(rd_b)
  );

  assign m_tuser = {6'b0, status};
  assign m_tdata = {2'b0, occupancy, is_palindrome, popped_value};

endmodule

/* sim/tb_stack_with_palindrome_check_unit.sv */
// Self-checking testbench for stack_with_palindrome_check_unit.
// Drives a directed table, then random push/pop/check runs with stream gaps and stalls.
// Checks every result against a cycle-free stack predictor or a fixed table row; depends on swpc_pkg.
`timescale 1ns / 1ps

module tb_stack_with_palindrome_check_unit;
  import swpc_pkg::*;

  localparam logic [1:0] FN_NONE = 2'd3;
  localparam int RANDOM_ITEMS = 1900;
  localparam int DRAIN_CYCLES = 2 * (DEPTH / 2) + 20;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [1:0]        status;
    logic [WORD_W-1:0] popped;
    logic              pal;
    logic [OCC_W-1:0]  occ;
  } stack_result_t;

  typedef struct packed {
    logic [1:0]        func;
    logic [WORD_W-1:0] value;
  } stack_op_t;

  typedef struct {
    stack_op_t     op;
    int            reps;
    bit            fixed;
    stack_result_t res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tuser = '0;   // [1:0] func
  logic [31:0] s_tdata = '0;   // [31:0] push_value
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tuser;        // [1:0] status
  logic [39:0] m_tdata;        // [31:0] popped_value, [32] is_palindrome, [37:33] occupancy

  stack_with_palindrome_check_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // Stack predictor state
  logic [WORD_W-1:0] stack_words [DEPTH];
  int                stack_fill = 0;
  stack_result_t     due_results [$];

  int errors = 0;
  int results_seen = 0;
  int ops_by_fn [4] = '{0, 0, 0, 0};
  int overflows = 0;
  int underflows = 0;
  int pal_hits = 0;

  int cycle_count = 0;
  bit calm_tx = 1'b0;
  bit calm_rx = 1'b0;

  stack_op_t op_plan [$];
  int        plan_fill;

  function automatic stack_result_t apply_stack_op(stack_op_t op);
    stack_result_t r;
    int lo;
    int hi;
    r = '0;
    r.status = ST_OK;
    ops_by_fn[op.func]++;
    case (op.func)
      FN_PUSH: begin
        if (stack_fill >= DEPTH) begin
          r.status = ST_OVERFLOW;
          overflows++;
        end else begin
          stack_words[stack_fill] = op.value;
          stack_fill++;
        end
      end
      FN_POP: begin
        if (stack_fill == 0) begin
          r.status = ST_UNDERFLOW;
          underflows++;
        end else begin
          stack_fill--;
          r.popped = stack_words[stack_fill];
        end
      end
      FN_CHECK: begin
        r.pal = 1'b1;
        lo = 0;
        hi = stack_fill;
        while (lo + 1 < hi) begin
          hi--;
          if (stack_words[lo] != stack_words[hi]) r.pal = 1'b0;
          lo++;
        end
        if (r.pal) pal_hits++;
      end
      default: ;
    endcase
    r.occ = stack_fill[OCC_W-1:0];
    return r;
  endfunction

  function automatic int pick_pause(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3: return 32'hFFFF_FFFF;
      4, 5: return $urandom_range(0, 3);
      default: return $urandom();
    endcase
  endfunction

  function automatic dir_row_t row(logic [1:0] func, logic [WORD_W-1:0] value, int reps,
                                   bit fixed, logic [1:0] status, logic [WORD_W-1:0] popped,
                                   logic pal, logic [OCC_W-1:0] occ);
    dir_row_t d;
    d.op.func = func;
    d.op.value = value;
    d.reps = reps;
    d.fixed = fixed;
    d.res.status = status;
    d.res.popped = popped;
    d.res.pal = pal;
    d.res.occ = occ;
    return d;
  endfunction

  task automatic plan_op(logic [1:0] func, logic [WORD_W-1:0] value);
    stack_op_t op;
    op.func = func;
    op.value = value;
    op_plan.push_back(op);
    if (func == FN_PUSH && plan_fill < DEPTH) plan_fill++;
    if (func == FN_POP && plan_fill > 0) plan_fill--;
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_op(stack_op_t op, bit fixed, stack_result_t fixed_res);
    int gap;
    stack_result_t r;
    gap = pick_pause(calm_tx);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= {6'd0, op.func};
    s_tdata  <= op.value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = apply_stack_op(op);
    due_results.push_back(fixed ? fixed_res : r);
    @(negedge clk);
  endtask

  function automatic void report_error(string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("%s", msg);
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 300 == 0) begin
      calm_tx <= ($urandom_range(0, 3) == 0);
      calm_rx <= ($urandom_range(0, 3) == 0);
    end
  end

  // Result side: random stalls on m_tready
  initial begin
    int stall;
    wait (!rst);
    @(negedge clk);
    forever begin
      stall = pick_pause(calm_rx);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    stack_result_t got;
    stack_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.status = m_tuser[1:0];
      got.popped = m_tdata[31:0];
      got.pal    = m_tdata[32];
      got.occ    = m_tdata[37:33];
      results_seen++;
      if (due_results.size() == 0) begin
        report_error($sformatf("unexpected result: status %0d popped %h pal %b occ %0d",
                               got.status, got.popped, got.pal, got.occ));
      end else begin
        want = due_results.pop_front();
        if (got !== want)
          report_error($sformatf(
            "result %0d: expected status %0d popped %h pal %b occ %0d, got %0d %h %b %0d",
            results_seen, want.status, want.popped, want.pal, want.occ,
            got.status, got.popped, got.pal, got.occ));
      end
    end
  end

  initial begin
    dir_row_t          dir_table [$];
    logic [WORD_W-1:0] pal_words [DEPTH];
    int                n;
    int                k;
    int                burst;

    // Directed table: fixed rows carry the result, the rest go through the predictor
    dir_table.push_back(row(FN_POP,   32'h0,         1, 1, ST_UNDERFLOW, 32'h0, 1'b0, 5'd0));
    dir_table.push_back(row(FN_CHECK, 32'h0,         1, 1, ST_OK, 32'h0, 1'b1, 5'd0));
    dir_table.push_back(row(FN_NONE,  32'hFFFF_FFFF, 1, 1, ST_OK, 32'h0, 1'b0, 5'd0));
    dir_table.push_back(row(FN_PUSH,  32'h8000_0000, 1, 1, ST_OK, 32'h0, 1'b0, 5'd1));
    dir_table.push_back(row(FN_CHECK, 32'h5555_5555, 1, 0, ST_OK, 32'h0, 1'b0, 5'd0));
    dir_table.push_back(row(FN_PUSH,  32'h7FFF_FFFF, 1, 1, ST_OK, 32'h0, 1'b0, 5'd2));
    dir_table.push_back(row(FN_CHECK, 32'hAAAA_AAAA, 1, 0, ST_OK, 32'h0, 1'b0, 5'd0));
    dir_table.push_back(row(FN_POP,   32'hFFFF_FFFF, 1, 1, ST_OK, 32'h7FFF_FFFF, 1'b0, 5'd1));
    dir_table.push_back(row(FN_POP,   32'h0,         1, 1, ST_OK, 32'h8000_0000, 1'b0, 5'd0));
    dir_table.push_back(row(FN_POP,   32'h0,         1, 1, ST_UNDERFLOW, 32'h0, 1'b0, 5'd0));
    dir_table.push_back(row(FN_PUSH,  32'hFFFF_FFFF, DEPTH, 0, ST_OK, 32'h0, 1'b0, 5'd0));
    dir_table.push_back(row(FN_CHECK, 32'h0,         1, 1, ST_OK, 32'h0, 1'b1, 5'd16));
    dir_table.push_back(row(FN_PUSH,  32'h0,         2, 1, ST_OVERFLOW, 32'h0, 1'b0, 5'd16));
    dir_table.push_back(row(FN_NONE,  32'h0,         1, 1, ST_OK, 32'h0, 1'b0, 5'd16));
    dir_table.push_back(row(FN_POP,   32'h0,         1, 1, ST_OK, 32'hFFFF_FFFF, 1'b0, 5'd15));
    dir_table.push_back(row(FN_CHECK, 32'h0,         1, 1, ST_OK, 32'h0, 1'b1, 5'd15));
    dir_table.push_back(row(FN_POP,   32'h0,         DEPTH - 1, 0, ST_OK, 32'h0, 1'b0, 5'd0));
    dir_table.push_back(row(FN_PUSH,  32'h5,         1, 0, ST_OK, 32'h0, 1'b0, 5'd0));
    dir_table.push_back(row(FN_PUSH,  32'h9,         1, 0, ST_OK, 32'h0, 1'b0, 5'd0));
    dir_table.push_back(row(FN_PUSH,  32'h5,         1, 0, ST_OK, 32'h0, 1'b0, 5'd0));
    dir_table.push_back(row(FN_CHECK, 32'h0,         1, 0, ST_OK, 32'h0, 1'b0, 5'd0));
    dir_table.push_back(row(FN_PUSH,  32'h5,         1, 0, ST_OK, 32'h0, 1'b0, 5'd0));
    dir_table.push_back(row(FN_CHECK, 32'h0,         1, 0, ST_OK, 32'h0, 1'b0, 5'd0));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_table[i])
      for (int j = 0; j < dir_table[i].reps; j++)
        send_op(dir_table[i].op, dir_table[i].fixed, dir_table[i].res);

    // Random episodes, planned against a running count of held entries
    plan_fill = stack_fill;
    while (op_plan.size() < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          repeat (20) begin
            k = $urandom_range(0, 99);
            if (k < 45) plan_op(FN_PUSH, pick_word());
            else if (k < 80) plan_op(FN_POP, pick_word());
            else if (k < 95) plan_op(FN_CHECK, pick_word());
            else plan_op(FN_NONE, pick_word());
          end
        end
        4, 5, 6: begin
          while (plan_fill > 0) plan_op(FN_POP, pick_word());
          n = $urandom_range(0, DEPTH);
          for (int i = 0; i < (n + 1) / 2; i++) begin
            pal_words[i] = pick_word();
            pal_words[n - 1 - i] = pal_words[i];
          end
          if (n > 0 && $urandom_range(0, 2) == 0) begin
            k = $urandom_range(0, n - 1);
            pal_words[k] ^= 32'd1 << $urandom_range(0, 31);
          end
          for (int i = 0; i < n; i++) plan_op(FN_PUSH, pal_words[i]);
          plan_op(FN_CHECK, pick_word());
          if ($urandom_range(0, 1) == 0) begin
            plan_op(FN_POP, pick_word());
            plan_op(FN_CHECK, pick_word());
          end
        end
        7: begin
          while (plan_fill < DEPTH) plan_op(FN_PUSH, pick_word());
          burst = $urandom_range(1, 3);
          repeat (burst) plan_op(FN_PUSH, pick_word());
          plan_op(FN_CHECK, pick_word());
        end
        8: begin
          while (plan_fill > 0) plan_op(FN_POP, pick_word());
          burst = $urandom_range(1, 3);
          repeat (burst) plan_op(FN_POP, pick_word());
          plan_op(FN_CHECK, pick_word());
        end
        default: begin
          repeat (10) plan_op(2'($urandom_range(0, 3)), $urandom());
        end
      endcase
    end

    foreach (op_plan[i]) send_op(op_plan[i], 1'b0, '0);
    s_tvalid <= 1'b0;

    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d operations: %0d push, %0d pop, %0d check, %0d unused code",
             ops_by_fn[0] + ops_by_fn[1] + ops_by_fn[2] + ops_by_fn[3],
             ops_by_fn[0], ops_by_fn[1], ops_by_fn[2], ops_by_fn[3]);
    $display("%0d results checked, %0d overflows, %0d underflows, %0d checks true",
             results_seen, overflows, underflows, pal_hits);
    if (errors == 0 && due_results.size() == 0) begin
      $display("status: pass");
    end else begin
      if (due_results.size() != 0) $display("%0d results never arrived", due_results.size());
      $display("%0d mismatches", errors);
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", due_results.size());
    $display("status: fail");
    $finish;
  end

endmodule
